/* rtl/sst_pkg.sv */
package sst_pkg;

  localparam int unsigned DATA_W       = 32;
  localparam int unsigned KIND_W       = 2;
  localparam int unsigned COUNT_W      = 5;
  localparam int unsigned CAPACITY_DEF = 16;

  // Request kinds. The unused code behaves as a query.
  localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd0;
  localparam logic [KIND_W-1:0] KIND_INSERT = 2'd1;
  localparam logic [KIND_W-1:0] KIND_REMOVE = 2'd2;

  // Action that every cell of the row applies in the same cycle.
  typedef enum logic [1:0] {
    OP_HOLD   = 2'd0,
    OP_INSERT = 2'd1,
    OP_REMOVE = 2'd2
  } cell_op_e;

  // What one cell shows to its neighbors and to the control logic.
  typedef struct packed {
    logic              valid;
    logic              lt;
    logic              eq;
    logic [DATA_W-1:0] entry;
  } cell_view_t;

  // Stand-in for the neighbor below cell 0: marks the slot of the new value.
  localparam cell_view_t VIEW_LOW  = '{valid: 1'b1, lt: 1'b1, eq: 1'b0, entry: '0};
  // Stand-in for the neighbor above the top cell: an empty slot.
  localparam cell_view_t VIEW_HIGH = '{valid: 1'b0, lt: 1'b0, eq: 1'b0, entry: '0};

endpackage

/* rtl/sst_cell.sv */
module sst_cell (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       cmp_en_i,
  input  sst_pkg::cell_op_e          op_i,
  input  logic [sst_pkg::DATA_W-1:0] value_i,
  input  sst_pkg::cell_view_t        prev_i,
  input  sst_pkg::cell_view_t        next_i,
  output sst_pkg::cell_view_t        view_o
);
  import sst_pkg::*;

  logic              valid_q, valid_d;
  logic              lt_q;
  logic              eq_q;
  logic [DATA_W-1:0] entry_q, entry_d;

  // Insert: cells at or above the slot take their lower neighbor's entry,
  // and the slot cell itself (lower neighbor is below the key) takes the value.
  // Remove: cells at or above the match take their upper neighbor's entry.
  always_comb begin
    valid_d = valid_q;
    entry_d = entry_q;
    case (op_i)
      OP_INSERT: begin
        if (!lt_q) begin
          valid_d = valid_q | prev_i.valid;
          entry_d = prev_i.lt ? value_i : prev_i.entry;
        end
      end
      OP_REMOVE: begin
        if (!lt_q) begin
          valid_d = next_i.valid;
          entry_d = next_i.entry;
        end
      end
      default: begin
        valid_d = valid_q;
        entry_d = entry_q;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      lt_q    <= 1'b0;
      eq_q    <= 1'b0;
    end else begin
      valid_q <= valid_d;
      if (cmp_en_i) begin
        lt_q <= valid_q && ($signed(entry_q) < $signed(value_i));
        eq_q <= valid_q && (entry_q == value_i);
      end
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign view_o = '{valid: valid_q, lt: lt_q, eq: eq_q, entry: entry_q};

endmodule

/* rtl/sorted_set_table.sv */
// Sorted set table: holds up to CAPACITY distinct signed 32-bit values in
// ascending order, one value per cell of a row of compare-and-shift cells.
// Input channel (in_valid_i / in_ready_o) carries one request: kind_i selects
// query, insert or remove (the unused code acts as a query), value_i is the
// value. Output channel (out_valid_o / out_ready_i) returns one result per
// request: present_o (value was held before the request), count_o (entries
// held after it, low five bits) and full_reject_o (insert dropped, table full).
// Each request passes the capture, compare and shift steps of the control
// sequencer: capture registers it, compare has every cell compare its entry
// with the value, and shift moves the row up or down by one cell and loads the
// result register. The result is visible the cycle after the shift step, and a
// new request is taken in that same cycle; none is taken while one is in flight.
// If the receiver stalls, the result waits in the output register while the
// next request is still captured and compared; its shift step then waits
// until the result register is free. Reset empties the table (all cell valid
// bits and the count clear) and drops any request or result in flight.
module sorted_set_table #(
  parameter int unsigned CAPACITY = sst_pkg::CAPACITY_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic        [sst_pkg::KIND_W-1:0] kind_i,
  input  logic signed [sst_pkg::DATA_W-1:0] value_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic                              present_o,
  output logic       [sst_pkg::COUNT_W-1:0] count_o,
  output logic                              full_reject_o
);
  import sst_pkg::*;

  localparam int unsigned CNT_W = $clog2(CAPACITY + 1);

  // One-hot control sequencer.
  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_CMP  = 3'b010,
    ST_ACT  = 3'b100
  } state_e;

  state_e             state_q, state_d;
  logic [KIND_W-1:0]  kind_q;
  logic [DATA_W-1:0]  value_q;
  logic [CNT_W-1:0]   count_q, count_d;
  logic               out_valid_q;
  logic               present_q;
  logic [COUNT_W-1:0] out_count_q;
  logic               reject_q;

  cell_view_t         views [CAPACITY];
  logic [CAPACITY-1:0] eq_vec;
  cell_op_e           op;
  logic               in_fire;
  logic               act_fire;
  logic               cmp_en;
  logic               present;
  logic               full;
  logic               do_ins;
  logic               do_rem;
  logic               reject;

  // Row of cells; each sees its two neighbors, the ends see fixed stand-ins.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    cell_view_t prev_view;
    cell_view_t next_view;
    if (i == 0) begin : g_lo
      assign prev_view = VIEW_LOW;
    end else begin : g_mid_lo
      assign prev_view = views[i-1];
    end
    if (i == CAPACITY - 1) begin : g_hi
      assign next_view = VIEW_HIGH;
    end else begin : g_mid_hi
      assign next_view = views[i+1];
    end
    assign eq_vec[i] = views[i].eq;

    sst_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .cmp_en_i (cmp_en),
      .op_i     (op),
      .value_i  (value_q),
      .prev_i   (prev_view),
      .next_i   (next_view),
      .view_o   (views[i])
    );
  end

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_fire    = in_valid_i && in_ready_o;
  assign cmp_en     = (state_q == ST_CMP);
  // The shift step may only run when the result register can take its result.
  assign act_fire   = (state_q == ST_ACT) && (!out_valid_q || out_ready_i);

  // Membership from the registered compare flags; the top cell's valid bit
  // tells whether the table is full.
  assign present = |eq_vec;
  assign full    = views[CAPACITY-1].valid;
  assign do_ins  = (kind_q == KIND_INSERT) && !present && !full;
  assign reject  = (kind_q == KIND_INSERT) && !present && full;
  assign do_rem  = (kind_q == KIND_REMOVE) && present;

  always_comb begin
    op = OP_HOLD;
    if (act_fire && do_ins) begin
      op = OP_INSERT;
    end else if (act_fire && do_rem) begin
      op = OP_REMOVE;
    end
  end

  always_comb begin
    count_d = count_q;
    if (do_ins) begin
      count_d = count_q + CNT_W'(1);
    end else if (do_rem) begin
      count_d = count_q - CNT_W'(1);
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_IDLE: begin
        if (in_fire) begin
          state_d = ST_CMP;
        end
      end
      ST_CMP: begin
        state_d = ST_ACT;
      end
      ST_ACT: begin
        if (act_fire) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      count_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (act_fire) begin
        count_q     <= count_d;
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Request and result payload registers.
  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      kind_q  <= kind_i;
      value_q <= value_i;
    end
    if (act_fire) begin
      present_q   <= present;
      out_count_q <= COUNT_W'(count_d);
      reject_q    <= reject;
    end
  end

  assign out_valid_o   = out_valid_q;
  assign present_o     = present_q;
  assign count_o       = out_count_q;
  assign full_reject_o = reject_q;

endmodule

/* rtl/sst_chk.sv */
module sst_chk (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        in_valid_i,
  input logic                        in_ready_o,
  input logic                        out_valid_o,
  input logic                        out_ready_i,
  input logic                        present_o,
  input logic [sst_pkg::COUNT_W-1:0] count_o,
  input logic                        full_reject_o
);

  // A dropped insert always concerns a value that was absent.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o |-> !(full_reject_o && present_o))
    else $error("full_reject_o raised for a value that was present");

  // The block works on one request at a time.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o) |=> !in_ready_o)
    else $error("second request taken while one is in progress");

  // With the result side empty, a request's result shows after the shift step.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (in_valid_i && in_ready_o && !out_valid_o) |-> ##3 out_valid_o)
    else $error("result did not appear three cycles after the request");

  // A stalled result holds its count.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_ready_i) |=> (out_valid_o && $stable(count_o)))
    else $error("stalled result dropped or changed");

endmodule

bind sorted_set_table sst_chk u_sst_chk (.*);

/* test/tb_sorted_set_table.sv */
`timescale 1ns / 100ps

// Testbench for the sorted set table. Requests are offered on the input channel
// and every result is checked against a shadow copy of the set. The shadow copy
// is a sorted queue that is updated the moment a request is accepted.
module tb_sorted_set_table;
  import sst_pkg::*;

  localparam int unsigned TABLE_CAP = CAPACITY_DEF;
  // The fourth kind code has no name in the package. The block treats it as a query.
  localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 200000;
  localparam int POOL_SIZE = 24;
  localparam int BURST_LEN = 40;

  typedef struct packed {
    logic               present;
    logic [COUNT_W-1:0] count;
    logic               full_reject;
  } set_result_t;

  logic                     clk_i = 1'b0;
  logic                     rst_ni = 1'b0;
  logic                     in_valid_i = 1'b0;
  logic                     in_ready_o;
  logic        [KIND_W-1:0] kind_i = KIND_QUERY;
  logic signed [DATA_W-1:0] value_i = '0;
  logic                     out_valid_o;
  logic                     out_ready_i = 1'b0;
  logic                     present_o;
  logic       [COUNT_W-1:0] count_o;
  logic                     full_reject_o;

  sorted_set_table #(
    .CAPACITY(TABLE_CAP)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_valid_i   (in_valid_i),
    .in_ready_o   (in_ready_o),
    .kind_i       (kind_i),
    .value_i      (value_i),
    .out_valid_o  (out_valid_o),
    .out_ready_i  (out_ready_i),
    .present_o    (present_o),
    .count_o      (count_o),
    .full_reject_o(full_reject_o)
  );

  // The shadow set holds its values in ascending signed order, as the row of cells does.
  logic signed [DATA_W-1:0] held_values[$];
  set_result_t              pending_results[$];
  int                       error_count = 0;
  int                       cycle_count = 0;

  // These settings control the traffic. The test tasks change them between phases.
  int sender_idle_pct = 0;
  int receiver_stall_pct = 0;
  // While this count is above zero, the receiver keeps ready low. It counts down one per cycle.
  int hold_off_left = 0;

  logic signed [DATA_W-1:0] value_pool[POOL_SIZE];

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // This limit covers the slowest correct run several times over. About 1100
  // requests each pass the capture, compare and shift steps of the block, plus
  // the gaps on both sides and one long hold-off of the receiver.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  // The long hold-off of the receiver counts down here, one step per cycle.
  always @(posedge clk_i) begin
    if (hold_off_left > 0) begin
      hold_off_left--;
    end
  end

  // This function applies one request to the shadow set and returns the result
  // that the block must give. The result reports whether the value was held
  // before the request and how many values are held after it. An insert of an
  // absent value into a full table changes nothing and raises full_reject.
  function automatic set_result_t predict_set_op(input logic [KIND_W-1:0] kind,
                                                 input logic signed [DATA_W-1:0] value);
    set_result_t res;
    int pos;
    pos = 0;
    foreach (held_values[i]) begin
      if (held_values[i] < value) pos++;
    end
    res.present = (pos < held_values.size()) && (held_values[pos] == value);
    res.full_reject = 1'b0;
    case (kind)
      KIND_INSERT: begin
        if (!res.present) begin
          if (held_values.size() >= TABLE_CAP) res.full_reject = 1'b1;
          else held_values.insert(pos, value);
        end
      end
      KIND_REMOVE: begin
        if (res.present) held_values.delete(pos);
      end
      default: ;  // A query and the unused code leave the set as it is.
    endcase
    res.count = COUNT_W'(held_values.size());
    return res;
  endfunction

  // This task offers one request and returns at the edge where it is accepted.
  // It leaves valid high on return. The next call then either drops valid for
  // an idle gap or replaces the payload directly, so valid gets only one
  // assignment in any time step.
  task automatic send_request(input logic [KIND_W-1:0] kind,
                              input logic signed [DATA_W-1:0] value);
    if ($urandom_range(99) < sender_idle_pct) begin
      in_valid_i <= 1'b0;
      kind_i     <= KIND_W'($urandom_range(3));
      value_i    <= $urandom;
      do @(posedge clk_i); while ($urandom_range(99) < sender_idle_pct);
    end
    in_valid_i <= 1'b1;
    kind_i     <= kind;
    value_i    <= value;
    do @(posedge clk_i); while (!in_ready_o);
    pending_results.push_back(predict_set_op(kind, value));
  endtask

  task automatic report_mismatch(input string field, input int unsigned want,
                                 input int unsigned got);
    $display("%0t: mismatch on %s: expected %0d, actual %0d", $time, field, want, got);
    error_count++;
  endtask

  // The receiver checks each result that is accepted at this edge against the
  // oldest pending prediction. It then chooses the value of ready for the next cycle.
  always @(posedge clk_i) begin
    set_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        $display("%0t: result with no request pending: present %0d count %0d reject %0d",
                 $time, present_o, count_o, full_reject_o);
        error_count++;
      end else begin
        want = pending_results.pop_front();
        if (present_o !== want.present) report_mismatch("present", want.present, present_o);
        if (count_o !== want.count) report_mismatch("count", want.count, count_o);
        if (full_reject_o !== want.full_reject) begin
          report_mismatch("full_reject", want.full_reject, full_reject_o);
        end
      end
    end
    if (hold_off_left > 0) begin
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= ($urandom_range(99) >= receiver_stall_pct);
    end
  end

  // This test covers the extreme values, every kind code, an insert of a value
  // that is already present, and a remove of a value that is absent.
  task automatic test_basic_ops();
    send_request(KIND_QUERY, 32'sh8000_0000);     // The table is still empty.
    send_request(KIND_INSERT, 32'sh7fff_ffff);
    send_request(KIND_INSERT, 32'sh8000_0000);
    send_request(KIND_INSERT, 32'sd0);
    send_request(KIND_INSERT, -32'sd1);
    send_request(KIND_INSERT, 32'sh8000_0000);    // This value is already held.
    send_request(KIND_UNUSED, 32'sd0);
    send_request(KIND_QUERY, 32'sd1);
    send_request(KIND_REMOVE, -32'sd1);
    send_request(KIND_REMOVE, -32'sd1);           // This value is already gone.
  endtask

  // This test fills the table to capacity. An absent value must then be
  // rejected. A value that is present must be reported as present, without a reject.
  task automatic test_full_table();
    for (int i = 1; held_values.size() < TABLE_CAP; i++) begin
      send_request(KIND_INSERT, i * 100);
    end
    send_request(KIND_INSERT, 32'sd50);
    send_request(KIND_INSERT, 32'sd100);
  endtask

  function automatic logic [KIND_W-1:0] pick_kind(input bit grow);
    int r;
    r = $urandom_range(99);
    if (r < (grow ? 55 : 20)) return KIND_INSERT;
    if (r < 70) return KIND_REMOVE;
    if (r < 95) return KIND_QUERY;
    return KIND_UNUSED;
  endfunction

  // Values come mostly from a pool slightly larger than the table, so hits,
  // misses, full rejects and emptying all happen often. The rest are fully
  // random words, so that every bit of the value field takes both levels.
  // Bursts that favor insert alternate with bursts that favor remove. This
  // moves the fill level between empty and full many times.
  task automatic test_random_traffic(input int idle_pct, input int stall_pct, input int n);
    logic signed [DATA_W-1:0] value;
    sender_idle_pct = idle_pct;
    receiver_stall_pct = stall_pct;
    value_pool[0] = 32'sh8000_0000;
    value_pool[1] = 32'sh7fff_ffff;
    value_pool[2] = 32'sd0;
    value_pool[3] = -32'sd1;
    for (int i = 4; i < POOL_SIZE; i++) begin
      value_pool[i] = (i % 2) ? $signed(32'($urandom_range(60))) - 30 : $signed($urandom);
    end
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(99) < 75) value = value_pool[$urandom_range(POOL_SIZE - 1)];
      else value = $urandom;
      send_request(pick_kind(((i / BURST_LEN) % 2) == 0), value);
    end
  endtask

  // In this test the receiver holds off for a long stretch while requests keep
  // coming. The result register and the request in flight back up, and the
  // block has to stop accepting input until ready returns.
  task automatic test_output_backpressure();
    sender_idle_pct = 0;
    receiver_stall_pct = 0;
    hold_off_left = 150;
    for (int i = 0; i < 20; i++) begin
      send_request(pick_kind(i < 12), value_pool[$urandom_range(POOL_SIZE - 1)]);
    end
  endtask

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_basic_ops();
    test_full_table();
    test_random_traffic(0, 0, 260);
    test_random_traffic(58, 0, 260);
    test_random_traffic(0, 58, 260);
    test_random_traffic(7, 7, 260);
    test_output_backpressure();

    // Drop valid, wait for the last result, then wait on so that any stray
    // result can show up.
    in_valid_i <= 1'b0;
    receiver_stall_pct = 0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);

    if (error_count == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule

/* files.f */
rtl/sst_pkg.sv
rtl/sst_cell.sv
rtl/sorted_set_table.sv
rtl/sst_chk.sv
test/tb_sorted_set_table.sv
